FILE: src/fenwick_range_sum_table_core_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on the rising
// edge and is switched off while the asynchronous reset is asserted.
`ifndef FENWICK_RANGE_SUM_TABLE_CORE_MACROS_SVH
`define FENWICK_RANGE_SUM_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_SAME(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/frs_pkg.sv
package frs_pkg;

	// Number of tree positions and derived widths.
	localparam int SIZE    = 1024;
	localparam int IDX_W   = 10;
	localparam int K_W     = IDX_W + 2;
	localparam int SUM_W   = 64;
	localparam int DELTA_W = 32;

	// Operation codes carried on the mode field.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_DISPATCH = 8'b0000_0100,
		ST_UPD_RD   = 8'b0000_1000,
		ST_UPD_WR   = 8'b0001_0000,
		ST_Q_LAST   = 8'b0010_0000,
		ST_Q_FIRST  = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_wr;
		logic rd_en;
		logic acc_en;
		logic acc_sub;
		logic wr_en;
		logic step_up;
		logic step_down;
		logic load_second;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic k_act;
		logic clr_done;
		logic is_query;
		logic query_bad;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: src/fenwick_range_sum_table_core.sv
// Fenwick range-sum table.
// Update: a read, then a write, for each tree level visited.
// Query: one read per level in each of the two prefix walks; an invalid query skips both walks.
// One item at a time; the result register frees the core while a result waits.
// After reset the tree is cleared, one entry a cycle, over all SIZE (1024) entries;
// in_ready stays low during that pass.
module fenwick_range_sum_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [frs_pkg::IDX_W-1:0]           first_index,
	input  logic [frs_pkg::IDX_W-1:0]           last_index,
	input  logic signed [frs_pkg::DELTA_W-1:0]  delta,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [frs_pkg::SUM_W-1:0]    range_sum,
	output logic                                range_error
);
	import frs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer for the clearing pass, update and query walks.
	frs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Tree memory, walk index, accumulator and result register.
	frs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.first_index (first_index),
		.last_index  (last_index),
		.delta       (delta),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.range_sum   (range_sum),
		.range_error (range_error)
	);

endmodule

FILE: src/frs_ctrl.sv
module frs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  frs_pkg::dp_stat_t stat,
	output frs_pkg::dp_cmd_t  cmd
);
	import frs_pkg::*;

	state_t state_q;
	state_t state_d;

	// Input items are taken only when no other item is in progress.
	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!stat.is_query) begin
					state_d = ST_UPD_RD;
				end else if (stat.query_bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_Q_LAST;
				end
			end
			ST_UPD_RD: begin
				if (stat.k_act) begin
					cmd.rd_en = 1'b1;
					state_d   = ST_UPD_WR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_UPD_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.step_up = 1'b1;
				state_d     = ST_UPD_RD;
			end
			ST_Q_LAST: begin
				if (stat.k_act) begin
					cmd.rd_en     = 1'b1;
					cmd.acc_en    = 1'b1;
					cmd.step_down = 1'b1;
				end else begin
					cmd.load_second = 1'b1;
					state_d         = ST_Q_FIRST;
				end
			end
			ST_Q_FIRST: begin
				if (stat.k_act) begin
					cmd.rd_en     = 1'b1;
					cmd.acc_en    = 1'b1;
					cmd.acc_sub   = 1'b1;
					cmd.step_down = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/frs_datapath.sv
`include "fenwick_range_sum_table_core_macros.svh"

module frs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  frs_pkg::dp_cmd_t                     cmd,
	output frs_pkg::dp_stat_t                    stat,
	input  logic                                mode,
	input  logic [frs_pkg::IDX_W-1:0]           first_index,
	input  logic [frs_pkg::IDX_W-1:0]           last_index,
	input  logic signed [frs_pkg::DELTA_W-1:0]  delta,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [frs_pkg::SUM_W-1:0]    range_sum,
	output logic                                range_error
);
	import frs_pkg::*;

	logic [SUM_W-1:0]            mem [SIZE];
	logic [SUM_W-1:0]            rdata_q;
	logic [IDX_W-1:0]            waddr_q;
	logic [IDX_W-1:0]            clr_q;
	logic [K_W-1:0]              k_q;
	logic [K_W-1:0]              k_low;
	logic [K_W-1:0]              k_dec;
	logic                        mode_q;
	logic [IDX_W-1:0]            first_q;
	logic [IDX_W-1:0]            last_q;
	logic signed [DELTA_W-1:0]   delta_q;
	logic signed [SUM_W-1:0]     acc_q;
	logic                        pend_q;
	logic                        pend_sub_q;
	logic                        out_valid_q;
	logic signed [SUM_W-1:0]     range_sum_q;
	logic                        range_error_q;
	logic                        bad;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	logic [SUM_W-1:0]            mem_wdata;

	// Lowest set bit of the walk index and the memory address it selects.
	assign k_low = k_q & (~k_q + K_W'(1));
	assign k_dec = k_q - K_W'(1);

	// A query is invalid past the end of the table or when reversed.
	assign bad = ({{(K_W-IDX_W){1'b0}}, last_q} >= K_W'(SIZE)) || (first_q > last_q);

	assign stat.k_act     = (k_q != '0) && (k_q <= K_W'(SIZE));
	assign stat.clr_done  = (clr_q == IDX_W'(SIZE - 1));
	assign stat.is_query  = (mode_q == OP_QUERY);
	assign stat.query_bad = bad;
	assign stat.out_free  = !out_valid_q || out_ready;

	// Write port: zeros during the clearing pass, otherwise read-modify-write.
	assign mem_we    = cmd.clr_wr || cmd.wr_en;
	assign mem_waddr = cmd.clr_wr ? clr_q : waddr_q;
	assign mem_wdata = cmd.clr_wr ? '0 : rdata_q + SUM_W'(delta_q);

	// Tree memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[k_dec[IDX_W-1:0]];
			waddr_q <= k_dec[IDX_W-1:0];
		end
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			first_q <= first_index;
			last_q  <= last_index;
			delta_q <= delta;
		end
	end

	// Walk index: starts one past the position, then follows the low-bit chain.
	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			k_q <= (mode == OP_QUERY) ? ({{(K_W-IDX_W){1'b0}}, last_index} + K_W'(1))
			                          : ({{(K_W-IDX_W){1'b0}}, first_index} + K_W'(1));
		end else if (cmd.load_second) begin
			k_q <= {{(K_W-IDX_W){1'b0}}, first_q};
		end else if (cmd.step_up) begin
			k_q <= k_q + k_low;
		end else if (cmd.step_down) begin
			k_q <= k_q - k_low;
		end
	end

	// Accumulator adds or subtracts (pend_sub_q) each query read from the registered read data flagged by pend_q.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (pend_q) begin
			acc_q <= pend_sub_q ? acc_q - $signed(rdata_q) : acc_q + $signed(rdata_q);
		end
	end

	// Control flags: pending read, clearing counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_sub_q  <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q     <= cmd.rd_en && cmd.acc_en;
			pend_sub_q <= cmd.acc_sub;
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register holds a result until it is taken.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			range_sum_q   <= bad ? '0 : acc_q;
			range_error_q <= bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign range_sum   = range_sum_q;
	assign range_error = range_error_q;

	`FRS_ASSERT_SAME(a_err_zero, clk, arst_n, out_valid_q && range_error_q, range_sum_q == '0, "error result carries a nonzero sum")
	`FRS_ASSERT_SAME(a_no_wr_in_query, clk, arst_n, pend_q, !mem_we, "tree written while a query read is pending")
	`FRS_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || out_ready, "result register overwritten before it was taken")
	`FRS_ASSERT_NEXT(a_walk_down, clk, arst_n, cmd.step_down && !cmd.load, k_q < $past(k_q), "prefix walk index did not decrease")

endmodule
